[sv/pfsd_pkg.sv]
// shared types and constants for the per-flow serialized dispatcher
// used by every module of the block except pfsd_ram; no dependencies
package pfsd_pkg;

  localparam int NUM_FLOWS_DEF   = 64;
  localparam int PENDING_MAX_DEF = 255;

  localparam int MODE_W      = 2;
  localparam int FLOW_W      = 6;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUBMIT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_DISPATCH = 2'd2,
    MODE_COMPLETE = 2'd3
  } pfsd_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 3'd0,
    STAT_DISPATCHED = 3'd1,
    STAT_EMPTY      = 3'd2,
    STAT_IGNORED    = 3'd3,
    STAT_SATURATED  = 3'd4
  } pfsd_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_DSP,
    S_PURGE,
    S_RM_FIN
  } pfsd_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic rdy;
    logic take;
    logic upd_fire;
    logic head_cap;
    logic dsp_fire;
    logic prg_init;
    logic prg_step;
    logic rm_fire;
  } pfsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    pfsd_mode_e mode;
    logic       oor;
    logic       fifo_empty;
    logic       clear_last;
    logic       prg_done;
    logic       out_free;
  } pfsd_stat_t;

endpackage

[sv/per_flow_serialized_dispatcher_core.sv]
// top level of the per-flow serialized dispatcher
// depends on pfsd_pkg, pfsd_ctrl, pfsd_dpath (and pfsd_ram below it)
//
// Each input beat carries an operation (submit, remove, dispatch, complete) and a flow id;
// each one yields exactly one result beat with a status and, for a dispatch, the flow handed
// out. A per-flow table in ram (live, queued, active, pending count) and a circular ready
// fifo in ram make sure a flow never has two jobs running. One item is worked at a time:
// submit and complete do one read-modify-write of the flow table, dispatch reads the
// fifo head and then the table, and remove runs a purge that streams the fifo through
// its single read port while compacting it. The result sits in an output register, so
// the next beat is taken while it waits. After reset the block sweeps the flow table to
// zero and holds s_axis_tready low during the sweep.
module per_flow_serialized_dispatcher_core #(
  parameter int NUM_FLOWS   = pfsd_pkg::NUM_FLOWS_DEF,
  parameter int PENDING_MAX = pfsd_pkg::PENDING_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pfsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] mode, [7:2] flow_id
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pfsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [2:0] status, [8:3] dispatched_flow
);

  localparam int PadW = pfsd_pkg::OUT_TDATA_W - pfsd_pkg::STATUS_W - pfsd_pkg::FLOW_W;

  pfsd_pkg::pfsd_cmd_t  cmd;
  pfsd_pkg::pfsd_stat_t stat;

  logic [pfsd_pkg::STATUS_W-1:0] out_status;
  logic [pfsd_pkg::FLOW_W-1:0]   out_flow;

  pfsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfsd_dpath #(
    .NUM_FLOWS   (NUM_FLOWS),
    .PENDING_MAX (PENDING_MAX)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_data_i    (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_flow_o   (out_flow)
  );

  assign s_axis_tready = cmd.rdy;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_flow, out_status};

endmodule

[sv/pfsd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module pfsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pfsd_ctrl.sv]
// controller state machine of the dispatcher
// depends on pfsd_pkg for the state, command and status types
module pfsd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  pfsd_pkg::pfsd_stat_t   stat_i,
  output pfsd_pkg::pfsd_cmd_t    cmd_o
);

  pfsd_pkg::pfsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfsd_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pfsd_pkg::S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = pfsd_pkg::S_IDLE;
        end
      end
      pfsd_pkg::S_IDLE: begin
        cmd_o.rdy = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = pfsd_pkg::S_UPD;
        end
      end
      pfsd_pkg::S_UPD: begin
        if (stat_i.mode == pfsd_pkg::MODE_REMOVE && !stat_i.oor) begin
          cmd_o.prg_init = 1'b1;
          state_d        = pfsd_pkg::S_PURGE;
        end else if (stat_i.mode == pfsd_pkg::MODE_DISPATCH && !stat_i.fifo_empty) begin
          cmd_o.head_cap = 1'b1;
          state_d        = pfsd_pkg::S_DSP;
        end else if (stat_i.out_free) begin
          cmd_o.upd_fire = 1'b1;
          state_d        = pfsd_pkg::S_IDLE;
        end
      end
      pfsd_pkg::S_DSP: begin
        if (stat_i.out_free) begin
          cmd_o.dsp_fire = 1'b1;
          state_d        = pfsd_pkg::S_IDLE;
        end
      end
      pfsd_pkg::S_PURGE: begin
        cmd_o.prg_step = 1'b1;
        if (stat_i.prg_done) begin
          state_d = pfsd_pkg::S_RM_FIN;
        end
      end
      pfsd_pkg::S_RM_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.rm_fire = 1'b1;
          state_d       = pfsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfsd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[sv/pfsd_dpath.sv]
// datapath of the dispatcher: flow table ram, ready fifo ram, pointers, result register
// depends on pfsd_pkg and pfsd_ram
module pfsd_dpath #(
  parameter int NUM_FLOWS   = pfsd_pkg::NUM_FLOWS_DEF,
  parameter int PENDING_MAX = pfsd_pkg::PENDING_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfsd_pkg::pfsd_cmd_t            cmd_i,
  output pfsd_pkg::pfsd_stat_t           stat_o,
  input  logic [pfsd_pkg::IN_TDATA_W-1:0] in_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [pfsd_pkg::STATUS_W-1:0]  out_status_o,
  output logic [pfsd_pkg::FLOW_W-1:0]    out_flow_o
);

  localparam int IdxW  = $clog2(NUM_FLOWS);
  localparam int CntW  = $clog2(NUM_FLOWS + 1);
  localparam int PendW = $clog2(PENDING_MAX + 1);
  // table word: {live, queued, active, pending}
  localparam int EntW  = PendW + 3;
  localparam int LiveB = PendW + 2;
  localparam int QueB  = PendW + 1;
  localparam int ActB  = PendW;
  localparam int FlowW = pfsd_pkg::FLOW_W;

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(NUM_FLOWS - 1)) ? '0 : p + 1'b1;
  endfunction

  // captured item
  pfsd_pkg::pfsd_mode_e mode_q;
  logic [FlowW-1:0]     flow_q;
  logic [FlowW-1:0]     head_id_q;

  // fifo pointers
  logic [IdxW-1:0] head_q, tail_q, rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0] occ_q, rd_cnt_q, wr_cnt_q;
  logic            prg_vld_q;
  logic [IdxW-1:0] clr_cnt_q;

  // result register
  logic                         out_valid_q;
  logic [pfsd_pkg::STATUS_W-1:0] out_status_q;
  logic [FlowW-1:0]             out_flow_q;

  // ram ports
  logic            tbl_we;
  logic [IdxW-1:0] tbl_waddr, tbl_raddr;
  logic [EntW-1:0] tbl_wdata, tbl_rdata;
  logic            fifo_we;
  logic [IdxW-1:0] fifo_waddr, fifo_raddr;
  logic [FlowW-1:0] fifo_wdata, fifo_rdata;

  logic [FlowW-1:0] in_flow;
  logic             oor;
  logic             push;
  logic             sat;
  logic             keep;
  logic [PendW-1:0] pend_r;
  logic [EntW-1:0]  upd_ent;
  pfsd_pkg::pfsd_status_e upd_stat;
  logic             upd_we;

  assign in_flow = in_data_i[pfsd_pkg::MODE_W +: FlowW];
  assign oor     = 32'(flow_q) >= NUM_FLOWS;
  assign pend_r  = tbl_rdata[PendW-1:0];
  assign sat     = 32'(pend_r) >= PENDING_MAX;
  assign keep    = cmd_i.prg_step && prg_vld_q && (fifo_rdata != flow_q);

  // submit / completion / ignored / empty outcome
  always_comb begin
    upd_ent  = tbl_rdata;
    upd_stat = pfsd_pkg::STAT_DONE;
    upd_we   = 1'b0;
    push     = 1'b0;
    if (mode_q == pfsd_pkg::MODE_DISPATCH) begin
      upd_stat = pfsd_pkg::STAT_EMPTY;
    end else if (oor) begin
      upd_stat = pfsd_pkg::STAT_IGNORED;
    end else if (mode_q == pfsd_pkg::MODE_SUBMIT) begin
      upd_we          = 1'b1;
      upd_ent[LiveB]  = 1'b1;
      if (sat) begin
        upd_ent[PendW-1:0] = PendW'(PENDING_MAX);
        upd_stat           = pfsd_pkg::STAT_SATURATED;
      end else begin
        upd_ent[PendW-1:0] = pend_r + 1'b1;
      end
      push          = !tbl_rdata[ActB] && !tbl_rdata[QueB];
      upd_ent[QueB] = tbl_rdata[QueB] | push;
    end else if (mode_q == pfsd_pkg::MODE_COMPLETE) begin
      if (!tbl_rdata[ActB]) begin
        upd_stat = pfsd_pkg::STAT_IGNORED;
      end else begin
        upd_we        = 1'b1;
        upd_ent[ActB] = 1'b0;
        if (pend_r != '0) begin
          push          = !tbl_rdata[QueB];
          upd_ent[QueB] = 1'b1;
        end else begin
          upd_ent = '0;
        end
      end
    end
  end

  // table port muxing
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = IdxW'(flow_q);
    tbl_wdata = '0;
    if (cmd_i.clear_step) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_cnt_q;
    end else if (cmd_i.upd_fire) begin
      tbl_we    = upd_we;
      tbl_wdata = upd_ent;
    end else if (cmd_i.dsp_fire) begin
      tbl_we                = 1'b1;
      tbl_waddr             = IdxW'(head_id_q);
      tbl_wdata             = tbl_rdata;
      tbl_wdata[LiveB]      = 1'b1;
      tbl_wdata[QueB]       = 1'b0;
      tbl_wdata[ActB]       = 1'b1;
      if (pend_r != '0) begin
        tbl_wdata[PendW-1:0] = pend_r - 1'b1;
      end
    end else if (cmd_i.rm_fire) begin
      tbl_we = 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.rdy) begin
      tbl_raddr = IdxW'(in_flow);
    end else if (cmd_i.head_cap) begin
      tbl_raddr = IdxW'(fifo_rdata);
    end else if (mode_q == pfsd_pkg::MODE_DISPATCH) begin
      tbl_raddr = IdxW'(head_id_q);
    end else begin
      tbl_raddr = IdxW'(flow_q);
    end
  end

  // fifo port muxing
  assign fifo_raddr = cmd_i.prg_step ? rd_ptr_q : head_q;
  always_comb begin
    fifo_we    = 1'b0;
    fifo_waddr = tail_q;
    fifo_wdata = flow_q;
    if (cmd_i.upd_fire && push && (32'(occ_q) < NUM_FLOWS)) begin
      fifo_we = 1'b1;
    end else if (keep) begin
      fifo_we    = 1'b1;
      fifo_waddr = wr_ptr_q;
      fifo_wdata = fifo_rdata;
    end
  end

  pfsd_ram #(.WIDTH(EntW), .DEPTH(NUM_FLOWS)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  pfsd_ram #(.WIDTH(FlowW), .DEPTH(NUM_FLOWS)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= pfsd_pkg::pfsd_mode_e'(in_data_i[pfsd_pkg::MODE_W-1:0]);
      flow_q <= in_flow;
    end
    if (cmd_i.head_cap) begin
      head_id_q <= fifo_rdata;
    end
    if (cmd_i.upd_fire) begin
      out_status_q <= upd_stat;
      out_flow_q   <= '0;
    end else if (cmd_i.dsp_fire) begin
      out_status_q <= pfsd_pkg::STAT_DISPATCHED;
      out_flow_q   <= head_id_q;
    end else if (cmd_i.rm_fire) begin
      out_status_q <= pfsd_pkg::STAT_DONE;
      out_flow_q   <= '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      prg_vld_q   <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.upd_fire && push && (32'(occ_q) < NUM_FLOWS)) begin
        tail_q <= ptr_inc(tail_q);
        occ_q  <= occ_q + 1'b1;
      end
      if (cmd_i.dsp_fire) begin
        head_q <= ptr_inc(head_q);
        occ_q  <= occ_q - 1'b1;
      end
      if (cmd_i.prg_init) begin
        rd_ptr_q  <= head_q;
        wr_ptr_q  <= head_q;
        rd_cnt_q  <= '0;
        wr_cnt_q  <= '0;
        prg_vld_q <= 1'b0;
      end
      if (cmd_i.prg_step) begin
        // read one slot ahead, compact survivors behind it
        if (keep) begin
          wr_ptr_q <= ptr_inc(wr_ptr_q);
          wr_cnt_q <= wr_cnt_q + 1'b1;
        end
        if (rd_cnt_q != occ_q) begin
          rd_ptr_q  <= ptr_inc(rd_ptr_q);
          rd_cnt_q  <= rd_cnt_q + 1'b1;
          prg_vld_q <= 1'b1;
        end else begin
          prg_vld_q <= 1'b0;
        end
      end
      if (cmd_i.rm_fire) begin
        occ_q  <= wr_cnt_q;
        tail_q <= wr_ptr_q;
      end
      if (cmd_i.upd_fire || cmd_i.dsp_fire || cmd_i.rm_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.oor        = oor;
  assign stat_o.fifo_empty = (occ_q == '0);
  assign stat_o.clear_last = (clr_cnt_q == IdxW'(NUM_FLOWS - 1));
  assign stat_o.prg_done   = (rd_cnt_q == occ_q) && !prg_vld_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_flow_o   = out_flow_q;

endmodule
